@@ rtl/ata_pio_transfer_sequencer_core_defines.svh @@
// ----------------------------------------------------------------------------
// ATA PIO sequencer assertion macros
// Shared concurrent assertion forms for the sequencer port checker.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_TRANSFER_SEQUENCER_CORE_DEFINES_SVH
`define ATA_PIO_TRANSFER_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define ATA_SEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ata_seq: same-cycle check failed");

// next-cycle implication
`define ATA_SEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ata_seq: next-cycle check failed");

`endif

@@ rtl/ata_seq_pkg.sv @@
// ----------------------------------------------------------------------------
// ATA PIO sequencer package
// Codes, constants and the job record passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ata_seq_pkg;

  typedef enum logic [2:0] {
    OP_START_RD   = 3'd0,
    OP_START_WR   = 3'd1,
    OP_STATUS     = 3'd2,
    OP_DRIVE_WORD = 3'd3,
    OP_HOST_WORD  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ACT_WR_REG    = 3'd0,
    ACT_RD_STATUS = 3'd1,
    ACT_RD_DATA   = 3'd2,
    ACT_WR_DATA   = 3'd3,
    ACT_DELIVER   = 3'd4,
    ACT_FINISH    = 3'd5,
    ACT_NEED_HOST = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    OUT_OK        = 3'd0,
    OUT_REJECTED  = 3'd1,
    OUT_BSY_PRE   = 3'd2,
    OUT_BSY_POST  = 3'd3,
    OUT_DRQ_FAIL  = 3'd4,
    OUT_LATER     = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    JK_ONE = 2'd0,
    JK_TWO = 2'd1,
    JK_CMD = 2'd2
  } job_kind_t;

  localparam logic [1:0] CFG_DRIVE_TOTAL = 2'd0;
  localparam logic [1:0] CFG_DEVICE_SEL  = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT  = 2'd2;

  localparam logic [2:0] REG_SECCNT  = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_DEVICE  = 3'd6;
  localparam logic [2:0] REG_COMMAND = 3'd7;

  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
  localparam logic [7:0] DEV_LBA28     = 8'hE0;
  localparam logic [7:0] DEV_LBA48     = 8'h40;

  localparam int ST_BSY = 7;
  localparam int ST_DRQ = 3;
  localparam int ST_ERR = 0;

  localparam int LBA28_BITS = 28;

  localparam logic [47:0] DRIVE_TOTAL_RST = 48'd0;
  localparam logic [7:0]  DEVICE_SEL_RST  = 8'hA0;
  localparam logic [21:0] POLL_LIMIT_RST  = 22'd2000000;

  // one entry of the front-to-back queue
  typedef struct packed {
    job_kind_t   kind;
    act_t        a0;
    logic [15:0] v0;
    outcome_t    o0;
    act_t        a1;
    outcome_t    o1;
    logic [47:0] lba;
    logic [7:0]  cnt;
    logic [7:0]  dev;
    logic        wr;
  } job_t;

endpackage

@@ rtl/ata_seq_front.sv @@
// ----------------------------------------------------------------------------
// ATA PIO sequencer front end
// Takes input words, tracks the transfer phase and queues result jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_seq_front import ata_seq_pkg::*; #(
  parameter int MAX_SECTORS      = 8,
  parameter int WORDS_PER_SECTOR = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  input  logic [2:0]  in_op,
  input  logic [87:0] in_data,
  input  logic        q_full,
  output logic        in_ready,
  output logic        job_push,
  output job_t        job
);

  localparam int SEC_W = $clog2(MAX_SECTORS + 1);
  localparam int WL_W  = $clog2(WORDS_PER_SECTOR + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_BSY_PRE, PH_BSY_POST, PH_DRQ, PH_RDATA, PH_WDATA, PH_BSY_MID, PH_BSY_END
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic               wr_r, wr_nxt;
  logic [SEC_W-1:0]   sl_r, sl_nxt;
  logic [WL_W-1:0]    wl_r, wl_nxt;
  logic [21:0]        pc_r, pc_nxt;
  logic               first_r, first_nxt;
  logic [47:0]        lba_r, lba_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic [47:0]        drive_total_r;
  logic [7:0]         dev_sel_r;
  logic [21:0]        poll_limit_r;

  logic [47:0]        f_lba;
  logic [15:0]        f_cnt;
  logic [7:0]         f_st;
  logic [15:0]        f_word;
  logic               accept, bsy, drq, err, exh;
  logic [22:0]        pc_inc;
  logic [WL_W-1:0]    wl_dec;
  logic [SEC_W-1:0]   sl_dec;

  assign f_lba  = in_data[47:0];
  assign f_cnt  = in_data[63:48];
  assign f_st   = in_data[71:64];
  assign f_word = in_data[87:72];
  assign bsy    = f_st[ST_BSY];
  assign drq    = f_st[ST_DRQ];
  assign err    = f_st[ST_ERR];

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign pc_inc   = {1'b0, pc_r} + 23'd1;
  assign exh      = pc_inc >= {1'b0, poll_limit_r};
  assign wl_dec   = (wl_r != '0) ? wl_r - WL_W'(1) : wl_r;
  assign sl_dec   = (sl_r != '0) ? sl_r - SEC_W'(1) : sl_r;

  always_comb begin
    phase_nxt = phase_r;
    wr_nxt    = wr_r;
    sl_nxt    = sl_r;
    wl_nxt    = wl_r;
    pc_nxt    = pc_r;
    first_nxt = first_r;
    lba_nxt   = lba_r;
    cnt_nxt   = cnt_r;
    job_push  = 1'b0;
    job       = '0;
    job.kind  = JK_ONE;
    job.a0    = ACT_RD_STATUS;
    job.o0    = OUT_OK;
    job.a1    = ACT_RD_STATUS;
    job.o1    = OUT_OK;
    job.lba   = lba_r;
    job.cnt   = cnt_r;
    job.dev   = dev_sel_r;
    job.wr    = wr_r;
    if (accept) begin
      case (phase_r)
        PH_IDLE: begin
          if (in_op == OP_START_RD || in_op == OP_START_WR) begin
            job_push = 1'b1;
            if (drive_total_r == '0 || f_cnt == '0 || f_cnt > 16'(MAX_SECTORS)) begin
              job.a0 = ACT_FINISH;
              job.o0 = OUT_REJECTED;
            end else begin
              wr_nxt    = in_op[0];
              lba_nxt   = f_lba;
              cnt_nxt   = f_cnt[7:0];
              sl_nxt    = f_cnt[SEC_W-1:0];
              wl_nxt    = '0;
              first_nxt = 1'b1;
              pc_nxt    = '0;
              phase_nxt = PH_BSY_PRE;
            end
          end
        end
        PH_BSY_PRE, PH_BSY_POST, PH_BSY_MID, PH_BSY_END, PH_DRQ: begin
          if (in_op == OP_STATUS) begin
            job_push = 1'b1;
            pc_nxt   = pc_inc[21:0];
            if (phase_r == PH_DRQ) begin
              if (err || (!drq && exh)) begin
                phase_nxt = PH_IDLE;
                job.a0    = ACT_FINISH;
                job.o0    = (wr_r || first_r) ? OUT_DRQ_FAIL : OUT_LATER;
              end else if (drq) begin
                wl_nxt    = WL_W'(WORDS_PER_SECTOR);
                phase_nxt = wr_r ? PH_WDATA : PH_RDATA;
                job.a0    = wr_r ? ACT_NEED_HOST : ACT_RD_DATA;
              end
            end else if (!bsy || exh) begin
              case (phase_r)
                PH_BSY_PRE: begin
                  if (bsy) begin
                    phase_nxt = PH_IDLE;
                    job.a0    = ACT_FINISH;
                    job.o0    = OUT_BSY_PRE;
                  end else begin
                    job.kind  = JK_CMD;
                    pc_nxt    = '0;
                    phase_nxt = PH_BSY_POST;
                  end
                end
                PH_BSY_POST: begin
                  if (bsy) begin
                    phase_nxt = PH_IDLE;
                    job.a0    = ACT_FINISH;
                    job.o0    = OUT_BSY_POST;
                  end else begin
                    pc_nxt    = '0;
                    phase_nxt = PH_DRQ;
                  end
                end
                PH_BSY_MID: begin
                  pc_nxt    = '0;
                  phase_nxt = PH_DRQ;
                end
                default: begin
                  phase_nxt = PH_IDLE;
                  job.a0    = ACT_FINISH;
                  job.o0    = OUT_OK;
                end
              endcase
            end
          end
        end
        PH_RDATA, PH_WDATA: begin
          if ((in_op == OP_DRIVE_WORD && phase_r == PH_RDATA) ||
              (in_op == OP_HOST_WORD && phase_r == PH_WDATA)) begin
            job_push = 1'b1;
            job.kind = JK_TWO;
            job.a0   = wr_r ? ACT_WR_DATA : ACT_DELIVER;
            job.v0   = f_word;
            wl_nxt   = wl_dec;
            if (wl_dec == '0) begin
              sl_nxt    = sl_dec;
              first_nxt = 1'b0;
              pc_nxt    = '0;
              if (sl_dec == '0) begin
                if (wr_r) begin
                  phase_nxt = PH_BSY_END;
                end else begin
                  phase_nxt = PH_IDLE;
                  job.a1    = ACT_FINISH;
                end
              end else begin
                phase_nxt = wr_r ? PH_DRQ : PH_BSY_MID;
              end
            end else begin
              job.a1 = wr_r ? ACT_NEED_HOST : ACT_RD_DATA;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      wr_r          <= 1'b0;
      sl_r          <= '0;
      wl_r          <= '0;
      pc_r          <= '0;
      first_r       <= 1'b0;
      lba_r         <= '0;
      cnt_r         <= '0;
      drive_total_r <= DRIVE_TOTAL_RST;
      dev_sel_r     <= DEVICE_SEL_RST;
      poll_limit_r  <= POLL_LIMIT_RST;
    end else begin
      phase_r <= phase_nxt;
      wr_r    <= wr_nxt;
      sl_r    <= sl_nxt;
      wl_r    <= wl_nxt;
      pc_r    <= pc_nxt;
      first_r <= first_nxt;
      lba_r   <= lba_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DRIVE_TOTAL: drive_total_r <= cfg_wdata;
          CFG_DEVICE_SEL:  dev_sel_r     <= cfg_wdata[7:0];
          CFG_POLL_LIMIT:  poll_limit_r  <= cfg_wdata[21:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/ata_seq_fifo.sv @@
// ----------------------------------------------------------------------------
// ATA PIO sequencer job queue
// Small first-in first-out store of jobs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_seq_fifo import ata_seq_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/ata_seq_back.sv @@
// ----------------------------------------------------------------------------
// ATA PIO sequencer back end
// Expands queued jobs into result words into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_seq_back import ata_seq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_data,
  output logic        out_last
);

  localparam logic [3:0] STEP_CMD_LAST = 4'd10;
  localparam logic [3:0] STEP_SHORT    = 4'd4;

  logic [3:0]  step_r;
  logic        valid_r;
  logic [31:0] data_r;
  logic        last_r;

  logic        ext, advance, r_last;
  logic [3:0]  idx;
  act_t        r_act;
  logic [2:0]  r_off;
  logic [15:0] r_val;
  outcome_t    r_oc;
  logic [7:0]  cmd_byte;

  assign ext      = |head.lba[47:LBA28_BITS];
  assign idx      = ext ? step_r : step_r + STEP_SHORT;
  assign cmd_byte = head.wr ? (ext ? CMD_WRITE_EXT : CMD_WRITE)
                            : (ext ? CMD_READ_EXT : CMD_READ);
  assign advance  = !valid_r || out_ready;
  assign pop      = advance && !empty && r_last;

  always_comb begin
    r_act  = ACT_WR_REG;
    r_off  = '0;
    r_val  = '0;
    r_oc   = OUT_OK;
    r_last = 1'b1;
    case (head.kind)
      JK_ONE: begin
        r_act = head.a0;
        r_oc  = head.o0;
      end
      JK_TWO: begin
        if (step_r == '0) begin
          r_act  = head.a0;
          r_val  = head.v0;
          r_last = 1'b0;
        end else begin
          r_act = head.a1;
          r_oc  = head.o1;
        end
      end
      JK_CMD: begin
        r_last = (idx == STEP_CMD_LAST);
        case (idx)
          4'd0: begin r_off = REG_SECCNT;  r_val = 16'h0000; end
          4'd1: begin r_off = REG_LBA_LO;  r_val = {8'h00, head.lba[31:24]}; end
          4'd2: begin r_off = REG_LBA_MID; r_val = {8'h00, head.lba[39:32]}; end
          4'd3: begin r_off = REG_LBA_HI;  r_val = {8'h00, head.lba[47:40]}; end
          4'd4: begin r_off = REG_SECCNT;  r_val = {8'h00, head.cnt}; end
          4'd5: begin r_off = REG_LBA_LO;  r_val = {8'h00, head.lba[7:0]}; end
          4'd6: begin r_off = REG_LBA_MID; r_val = {8'h00, head.lba[15:8]}; end
          4'd7: begin r_off = REG_LBA_HI;  r_val = {8'h00, head.lba[23:16]}; end
          4'd8: begin
            r_off = REG_DEVICE;
            r_val = ext ? {8'h00, head.dev | DEV_LBA48}
                        : {8'h00, head.dev | DEV_LBA28 | {4'h0, head.lba[27:24]}};
          end
          4'd9: begin r_off = REG_COMMAND; r_val = {8'h00, cmd_byte}; end
          default: r_act = ACT_RD_STATUS;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      step_r  <= '0;
    end else if (advance) begin
      valid_r <= !empty;
      if (!empty) begin
        step_r <= r_last ? '0 : step_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      data_r <= {7'd0, r_oc, r_val, r_off, r_act};
      last_r <= r_last;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule

@@ rtl/ata_pio_transfer_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// ATA PIO transfer sequencer core
// Host-side LBA28/LBA48 PIO read and write sequencer, polled status.
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tuser operation, tdata request/status/word
// out_     out  out_tvalid/out_tready tdata bus action, tlast end of answer
// cfg_     in   cfg_we                cfg_index, cfg_wdata
//
// One input word per cycle is taken while the job queue has room.
// The back end registers each result word in its output stage; a command issue
// yields seven or eleven words, so the output stage sets the pace there.
// Synchronous active-low reset; configuration resets to its defaults.
// A stalled output holds its word and the queue absorbs input meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ata_pio_transfer_sequencer_core import ata_seq_pkg::*; #(
  parameter int MAX_SECTORS      = 8,
  parameter int WORDS_PER_SECTOR = 256,
  parameter int QUEUE_DEPTH      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // lba[47:0], sector_count[63:48],
                                  // status_byte[71:64], data_word[87:72]
  input  logic [2:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // action[2:0], reg_offset[5:3],
                                  // value[21:6], outcome[24:22], zero pad
  output logic        out_tlast
);

  job_t job, head;
  logic job_push, q_full, q_empty, q_pop;

  ata_seq_front #(
    .MAX_SECTORS      (MAX_SECTORS),
    .WORDS_PER_SECTOR (WORDS_PER_SECTOR)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .job_push  (job_push),
    .job       (job)
  );

  ata_seq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ata_seq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

@@ rtl/ata_seq_checker.sv @@
// ----------------------------------------------------------------------------
// ATA PIO sequencer port checker
// Concurrent checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ata_pio_transfer_sequencer_core_defines.svh"

module ata_seq_checker import ata_seq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  `ATA_SEQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `ATA_SEQ_ASSERT_SAME(a_finish_last, clk, rst_n, out_tvalid && out_tdata[2:0] == ACT_FINISH, out_tlast)
  `ATA_SEQ_ASSERT_SAME(a_outcome_zero, clk, rst_n, out_tvalid && out_tdata[2:0] != ACT_FINISH, out_tdata[24:22] == 3'd0)
  `ATA_SEQ_ASSERT_SAME(a_reg_not_last, clk, rst_n, out_tvalid && out_tdata[2:0] == ACT_WR_REG, !out_tlast && out_tdata[5:3] >= REG_SECCNT)

endmodule

bind ata_pio_transfer_sequencer_core ata_seq_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
